// ===== rtl/debug_port_serial_shifter_macros.svh =====
// Assertion macros for the debug port serial shifter checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DEBUG_PORT_SERIAL_SHIFTER_MACROS_SVH
`define DEBUG_PORT_SERIAL_SHIFTER_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define DPSS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define DPSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dpss_pkg.sv =====
// Shared constants for the debug port serial shifter.
// No dependencies; used by the top level and its checker.
`default_nettype none
package dpss_pkg;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned CNT_W       = 6;
	localparam int unsigned IN_DATA_W   = 40;
	localparam int unsigned OUT_DATA_W  = 40;

	localparam logic [CNT_W-1:0] LEN_FULL  = 6'd32;
	localparam logic [CNT_W-1:0] LEN_SHORT = 6'd7;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [1:0] ST_CORE_DATA = 2'd0;
	localparam logic [1:0] ST_SEQ_ERR   = 2'd1;
	localparam logic [1:0] ST_CORE_INT  = 2'd2;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_SEQ     = 2'd1;
	localparam logic [1:0] ERR_INT     = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/debug_port_serial_shifter.sv =====
// Debug port serial shifter: master side of a development-port serial transfer.
// Depends on dpss_pkg.
//
// Usage:
//   s_axis carries requests. tuser is the action: start (0) latches prefix and
//   tx_word and arms a transfer; tick (1) carries one DSDO sample and yields
//   at most one DSCK pulse with the DSDI level to drive.
//   m_axis returns exactly one result per request. tlast is done (last data
//   bit clocked); tdata holds pulse, DSDI level, ready, status, rx_word and
//   error code.
//   A request accepted at an edge shows its result at the output register
//   right after that edge. Throughput is one request per cycle while the
//   receiver keeps up; the sequencer state and the 32-bit word select sit
//   between the request handshake and the result register.
//   A stalled receiver holds the result register; s_axis_tready then drops
//   until the result is taken (the output register is reused in the cycle
//   it drains).
//   Reset clears the sequencer to idle, total bits to 32 and all latched
//   words and flags to zero; no result is pending after reset.
`default_nettype none
module debug_port_serial_shifter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [1:0] prefix, [33:2] tx_word, [34] dsdo_level, [39:35] zero
	input  wire logic [dpss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] action
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [0] clock_pulse, [1] dsdi_level, [2] ready_bit, [4:3] status,
	// [36:5] rx_word, [38:37] error_code, [39] zero
	output logic [dpss_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// done_res
	output logic                                  m_axis_tlast
);
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_WAIT = 3'd1,
		PH_MODE = 3'd2,
		PH_CTRL = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	localparam int unsigned WW = dpss_pkg::WORD_W;
	localparam int unsigned CW = dpss_pkg::CNT_W;

	phase_t          phase_q, phase_n;
	logic [1:0]      prefix_q, prefix_n;
	logic [WW-1:0]   send_q, send_n;
	logic [CW-1:0]   count_q, count_n;
	logic [CW-1:0]   total_q, total_n;
	logic [1:0]      status_q, status_n;
	logic            ready_q, ready_n;
	logic [WW-1:0]   rx_q, rx_n;

	logic            pulse, dsdi, done;
	logic [1:0]      err;
	logic [CW-1:0]   len;
	logic [4:0]      pos;

	logic            out_valid_q;
	logic            pulse_q, dsdi_q, done_q, ready_out_q;
	logic [1:0]      status_out_q, err_q;
	logic [WW-1:0]   rx_out_q;

	logic            in_accept;
	logic [1:0]      in_prefix;
	logic [WW-1:0]   in_word;
	logic            in_dsdo;

	assign in_prefix = s_axis_tdata[1:0];
	assign in_word   = s_axis_tdata[33:2];
	assign in_dsdo   = s_axis_tdata[34];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign len = prefix_q[1] ? dpss_pkg::LEN_SHORT : dpss_pkg::LEN_FULL;
	assign pos = 5'(len - 6'd1 - count_q);

	always_comb begin
		phase_n  = phase_q;
		prefix_n = prefix_q;
		send_n   = send_q;
		count_n  = count_q;
		total_n  = total_q;
		status_n = status_q;
		ready_n  = ready_q;
		rx_n     = rx_q;
		pulse    = 1'b0;
		dsdi     = 1'b0;
		done     = 1'b0;
		err      = dpss_pkg::ERR_OK;
		if (s_axis_tuser == dpss_pkg::ACT_START) begin
			prefix_n = in_prefix;
			send_n   = in_word;
			count_n  = '0;
			total_n  = dpss_pkg::LEN_FULL;
			status_n = dpss_pkg::ST_CORE_DATA;
			ready_n  = 1'b0;
			rx_n     = '0;
			phase_n  = PH_WAIT;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_n = PH_IDLE;
				end
				PH_WAIT: begin
					pulse = 1'b1;
					if (!in_dsdo) begin
						dsdi    = 1'b1;
						ready_n = in_dsdo;
						phase_n = PH_MODE;
					end
				end
				PH_MODE: begin
					pulse    = 1'b1;
					dsdi     = prefix_q[1];
					status_n = {in_dsdo, 1'b0};
					phase_n  = PH_CTRL;
				end
				PH_CTRL: begin
					pulse    = 1'b1;
					dsdi     = prefix_q[0];
					status_n = {status_q[1], in_dsdo};
					total_n  = (status_n != dpss_pkg::ST_CORE_DATA && prefix_q[1]) ?
						dpss_pkg::LEN_SHORT : dpss_pkg::LEN_FULL;
					count_n  = '0;
					phase_n  = PH_DATA;
				end
				PH_DATA: begin
					pulse   = 1'b1;
					dsdi    = (count_q < len) ? send_q[pos] : 1'b0;
					rx_n    = {rx_q[WW-2:0], in_dsdo};
					count_n = count_q + 6'd1;
					if (count_n >= total_q) begin
						done = 1'b1;
						if (status_q == dpss_pkg::ST_SEQ_ERR)
							err = dpss_pkg::ERR_SEQ;
						else if (status_q == dpss_pkg::ST_CORE_INT)
							err = dpss_pkg::ERR_INT;
						phase_n = PH_IDLE;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			prefix_q <= '0;
			send_q   <= '0;
			count_q  <= '0;
			total_q  <= dpss_pkg::LEN_FULL;
			status_q <= dpss_pkg::ST_CORE_DATA;
			ready_q  <= 1'b0;
			rx_q     <= '0;
		end else if (in_accept) begin
			phase_q  <= phase_n;
			prefix_q <= prefix_n;
			send_q   <= send_n;
			count_q  <= count_n;
			total_q  <= total_n;
			status_q <= status_n;
			ready_q  <= ready_n;
			rx_q     <= rx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pulse_q      <= pulse;
			dsdi_q       <= dsdi;
			done_q       <= done;
			ready_out_q  <= ready_n;
			status_out_q <= status_n;
			rx_out_q     <= rx_n;
			err_q        <= err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = done_q;
	assign m_axis_tdata  = {1'b0, err_q, rx_out_q, status_out_q, ready_out_q, dsdi_q, pulse_q};
endmodule
`default_nettype wire

// ===== rtl/dpss_checker.sv =====
// Port-level checker for the debug port serial shifter, bound to the top level.
// Depends on dpss_pkg and debug_port_serial_shifter_macros.svh.
`default_nettype none
`include "debug_port_serial_shifter_macros.svh"
module dpss_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             s_axis_tuser,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [dpss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input wire logic                             m_axis_tlast
);
	logic in_acc;
	logic start_acc;
	logic start_clear;
	logic err_flag;
	logic pulse_done;
	logic stalled;
	logic [dpss_pkg::OUT_DATA_W:0] out_bus;

	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign start_acc   = in_acc && (s_axis_tuser == dpss_pkg::ACT_START);
	assign start_clear = (m_axis_tdata[1:0] == 2'b00) && !m_axis_tlast &&
		(m_axis_tdata[36:2] == '0);
	assign err_flag    = m_axis_tvalid && (m_axis_tdata[38:37] != dpss_pkg::ERR_OK);
	assign pulse_done  = m_axis_tlast && m_axis_tdata[0];
	assign stalled     = m_axis_tvalid && !m_axis_tready;
	assign out_bus     = {m_axis_tlast, m_axis_tdata};

	// every request yields a result next cycle
	`DPSS_ASSERT_CLK(a_result_follows, clk, arst_n, in_acc |=> m_axis_tvalid, "request lost")
	// a start gives a quiet result with cleared latches
	`DPSS_ASSERT_CLK(a_start_quiet, clk, arst_n, start_acc |=> start_clear, "start not cleared")
	// error codes only together with done on a clocked bit
	`DPSS_ASSERT_CLK(a_err_done, clk, arst_n, err_flag |-> pulse_done, "error without done")
	// held result stays put
	`DPSS_ASSERT_CLK(a_hold, clk, arst_n, stalled |=> (m_axis_tvalid && $stable(out_bus)), "held")
	// nothing pending out of reset
	`DPSS_ASSERT_ALWAYS(a_reset_idle, clk, $rose(arst_n) |-> !m_axis_tvalid, "valid in reset")
endmodule

bind debug_port_serial_shifter dpss_checker u_dpss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== tb/sv/debug_port_serial_shifter_test.sv =====
// Self-checking testbench for debug_port_serial_shifter: a directed table, then random
// serial transfers, with every result compared against a fixed expectation or a behavioral predictor.
// Depends on dpss_pkg and the debug_port_serial_shifter RTL.
`timescale 1ns / 100ps

module debug_port_serial_shifter_test;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 600;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] ST_NULL = 2'd3;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_WAIT,
		SEQ_MODE,
		SEQ_CTRL,
		SEQ_DATA
	} seq_phase_t;

	typedef struct packed {
		logic        action;
		logic [1:0]  prefix;
		logic [31:0] tx_word;
		logic        dsdo;
	} shift_req_t;

	typedef struct packed {
		logic        pulse;
		logic        dsdi;
		logic        done;
		logic        ready;
		logic [1:0]  status;
		logic [31:0] rx_word;
		logic [1:0]  err;
	} shift_res_t;

	typedef struct packed {
		shift_req_t rq;
		logic       fixed;
		shift_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [dpss_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [dpss_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	stim_row_t serial_reqs[$];
	shift_res_t shift_results_due[$];
	int fail_count = 0;
	int cycle_count = 0;
	int directed_count = 0;
	bit hold_armed = 1'b0;

	// predictor state
	seq_phase_t seq_phase = SEQ_IDLE;
	logic [1:0]  sh_prefix = '0;
	logic [31:0] sh_word = '0;
	logic [5:0]  sh_count = '0;
	logic [5:0]  sh_total = dpss_pkg::LEN_FULL;
	logic [1:0]  sh_status = dpss_pkg::ST_CORE_DATA;
	logic        sh_ready = 1'b0;
	logic [31:0] sh_rx = '0;

	debug_port_serial_shifter uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic shift_res_t shift_step(input shift_req_t rq);
		shift_res_t r;
		logic [5:0] wlen;
		logic [5:0] pos;
		r = '0;
		wlen = sh_prefix[1] ? dpss_pkg::LEN_SHORT : dpss_pkg::LEN_FULL;
		if (rq.action == dpss_pkg::ACT_START) begin
			sh_prefix = rq.prefix;
			sh_word = rq.tx_word;
			sh_count = '0;
			sh_total = dpss_pkg::LEN_FULL;
			sh_status = dpss_pkg::ST_CORE_DATA;
			sh_ready = 1'b0;
			sh_rx = '0;
			seq_phase = SEQ_WAIT;
		end else begin
			case (seq_phase)
				SEQ_WAIT: begin
					r.pulse = 1'b1;
					if (!rq.dsdo) begin
						r.dsdi = 1'b1;
						sh_ready = rq.dsdo;
						seq_phase = SEQ_MODE;
					end
				end
				SEQ_MODE: begin
					r.pulse = 1'b1;
					r.dsdi = sh_prefix[1];
					sh_status = {rq.dsdo, 1'b0};
					seq_phase = SEQ_CTRL;
				end
				SEQ_CTRL: begin
					r.pulse = 1'b1;
					r.dsdi = sh_prefix[0];
					sh_status = sh_status | {1'b0, rq.dsdo};
					sh_total = (sh_status == dpss_pkg::ST_CORE_DATA) ?
						dpss_pkg::LEN_FULL : dpss_pkg::LEN_SHORT;
					if (wlen > sh_total)
						sh_total = wlen;
					sh_count = '0;
					seq_phase = SEQ_DATA;
				end
				SEQ_DATA: begin
					r.pulse = 1'b1;
					if (sh_count < wlen) begin
						pos = wlen - 6'd1 - sh_count;
						r.dsdi = sh_word[pos[4:0]];
					end
					sh_rx = {sh_rx[30:0], rq.dsdo};
					sh_count = sh_count + 6'd1;
					if (sh_count >= sh_total) begin
						r.done = 1'b1;
						if (sh_status == dpss_pkg::ST_SEQ_ERR)
							r.err = dpss_pkg::ERR_SEQ;
						else if (sh_status == dpss_pkg::ST_CORE_INT)
							r.err = dpss_pkg::ERR_INT;
						else
							r.err = dpss_pkg::ERR_OK;
						seq_phase = SEQ_IDLE;
					end
				end
				default: seq_phase = SEQ_IDLE;
			endcase
		end
		r.ready = sh_ready;
		r.status = sh_status;
		r.rx_word = sh_rx;
		return r;
	endfunction

	task automatic add_row(input shift_req_t rq, input logic fixed, input shift_res_t res);
		stim_row_t row;
		row.rq = rq;
		row.fixed = fixed;
		row.res = res;
		serial_reqs.push_back(row);
	endtask

	task automatic build_directed();
		// mode set, core interrupt status: seven data bits
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b1, '0);
		add_row({dpss_pkg::ACT_START, 2'b10, 32'hFFFF_FFFF, 1'b0}, 1'b1, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b1,
			{1'b1, 1'b1, 1'b0, 1'b0, dpss_pkg::ST_CORE_DATA, 32'h0, dpss_pkg::ERR_OK});
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b1}, 1'b1,
			{1'b1, 1'b1, 1'b0, 1'b0, dpss_pkg::ST_CORE_INT, 32'h0, dpss_pkg::ERR_OK});
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b1,
			{1'b1, 1'b0, 1'b0, 1'b0, dpss_pkg::ST_CORE_INT, 32'h0, dpss_pkg::ERR_OK});
		for (int k = 0; k < 6; k++)
			add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, ~k[0]}, 1'b0, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b1}, 1'b1,
			{1'b1, 1'b1, 1'b1, 1'b0, dpss_pkg::ST_CORE_INT, 32'h55, dpss_pkg::ERR_INT});
		// target busy, then a restart in the middle of the prefix
		add_row({dpss_pkg::ACT_START, 2'b01, 32'h0, 1'b1}, 1'b1, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd3, 32'hFFFF_FFFF, 1'b1}, 1'b1,
			{1'b1, 1'b0, 1'b0, 1'b0, dpss_pkg::ST_CORE_DATA, 32'h0, dpss_pkg::ERR_OK});
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b0, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b1}, 1'b0, '0);
		add_row({dpss_pkg::ACT_START, 2'b11, 32'hFFFF_FF2A, 1'b0}, 1'b1, '0);
		// null status with mode set
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b0, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b1}, 1'b0, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b1}, 1'b0, '0);
		for (int k = 0; k < 6; k++)
			add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b0, '0);
		add_row({dpss_pkg::ACT_TICK, 2'd0, 32'h0, 1'b0}, 1'b1,
			{1'b1, 1'b0, 1'b1, 1'b0, ST_NULL, 32'h0, dpss_pkg::ERR_OK});
		directed_count = serial_reqs.size();
	endtask

	task automatic build_random();
		shift_req_t xfer[$];
		int counted;
		int waits;
		int ndata;
		int cut;
		logic [1:0] pre;
		logic s1;
		logic s0;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			xfer.delete();
			pre = 2'($urandom_range(0, 3));
			xfer.push_back({dpss_pkg::ACT_START, pre, 32'($urandom), 1'($urandom)});
			waits = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
			repeat (waits)
				xfer.push_back({dpss_pkg::ACT_TICK, 2'($urandom), 32'($urandom), 1'b1});
			xfer.push_back({dpss_pkg::ACT_TICK, 2'($urandom), 32'($urandom), 1'b0});
			s1 = 1'($urandom);
			s0 = 1'($urandom);
			xfer.push_back({dpss_pkg::ACT_TICK, 2'($urandom), 32'($urandom), s1});
			xfer.push_back({dpss_pkg::ACT_TICK, 2'($urandom), 32'($urandom), s0});
			ndata = (pre[1] && {s1, s0} != dpss_pkg::ST_CORE_DATA) ? 7 : 32;
			repeat (ndata)
				xfer.push_back({dpss_pkg::ACT_TICK, 2'($urandom), 32'($urandom),
					1'($urandom)});
			// some transfers are cut short by the next start
			cut = xfer.size();
			if ($urandom_range(0, 5) == 0)
				cut = $urandom_range(1, xfer.size() - 1);
			for (int k = 0; k < cut; k++)
				add_row(xfer[k], 1'b0, '0);
			counted += cut;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3))
					add_row({dpss_pkg::ACT_TICK, 2'($urandom), 32'($urandom),
						1'($urandom)}, 1'b0, '0);
		end
	endtask

	task automatic offer(input shift_req_t rq);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, rq.dsdo, rq.tx_word, rq.prefix};
		s_axis_tuser <= rq.action;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// receiver: stall patterns that change from one random span to the next, plus one long hold-off
	initial begin
		int hold_left;
		int style;
		int span;
		hold_left = 0;
		style = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				style = $urandom_range(0, 2);
				span = $urandom_range(20, 120);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left = LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else begin
				case (style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 2) != 0);
					default: m_axis_tready <= span[2] | span[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		shift_res_t got;
		shift_res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast, m_axis_tdata[2],
				m_axis_tdata[4:3], m_axis_tdata[36:5], m_axis_tdata[38:37]};
			if (shift_results_due.size() == 0) begin
				$display("%0t: result with no request pending: expected none, actual %h",
					$time, got);
				fail_count++;
			end else begin
				want = shift_results_due.pop_front();
				check_field("clock_pulse", 32'(want.pulse), 32'(got.pulse));
				check_field("dsdi_level", 32'(want.dsdi), 32'(got.dsdi));
				check_field("done", 32'(want.done), 32'(got.done));
				check_field("ready_bit", 32'(want.ready), 32'(got.ready));
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("rx_word", want.rx_word, got.rx_word);
				check_field("error_code", 32'(want.err), 32'(got.err));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("debug_port_serial_shifter_test failed");
		$finish;
	end

	initial begin
		int burst_left;
		int drain_at;
		shift_res_t predicted;
		build_directed();
		build_random();
		drain_at = directed_count + (serial_reqs.size() - directed_count) / 2;
		burst_left = $urandom_range(1, 24);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < serial_reqs.size(); i++) begin
			if (i == directed_count) begin
				// keep requests coming while the receiver holds off
				hold_armed = 1'b1;
				burst_left = LONG_HOLD + 50;
			end
			if (i == drain_at) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (shift_results_due.size() != 0)
					@(posedge clk);
			end
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
			offer(serial_reqs[i].rq);
			burst_left--;
			predicted = shift_step(serial_reqs[i].rq);
			shift_results_due.push_back(serial_reqs[i].fixed ? serial_reqs[i].res : predicted);
		end
		s_axis_tvalid <= 1'b0;
		while (shift_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("debug_port_serial_shifter_test passed");
		else
			$display("debug_port_serial_shifter_test failed");
		$finish;
	end
endmodule
